### hdl/rbd_pkg.sv
// Shared constants, field widths, operation and status codes, and the
// command, status and configuration structs of the ring buffer deque.
// No dependencies.
package rbd_pkg;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W   = ADDR_W + 1;

   localparam int OP_W     = 3;
   localparam int IDX_W    = 8;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 3;
   localparam int LENGTH_W = 9;
   localparam int CMP_W    = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - FIELD_W - LENGTH_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;
   localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_READ_ONLY = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_VALUE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_READ_ONLY   = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] empty_value;
      logic               read_only;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic capture_direct;
      logic capture_ram;
   } cmd_type;

   typedef struct packed {
      logic needs_read;
      logic rsp_valid;
   } stat_type;

   // Ring slot of a logical position; both operands are below DEPTH.
   function automatic logic [ADDR_W-1:0] wrap_slot(input logic [ADDR_W-1:0] front,
                                                   input logic [COUNT_W-1:0] logical);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(logical);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

endpackage

### hdl/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: stream request and result channels
// and an APB-style configuration port. Depends on rbd_pkg, rbd_csr,
// rbd_ctrl and rbd_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tuser operation, tdata index, value
//   rsp      out        rsp_tvalid/rsp_tready  tuser status, tdata data, length
//   csr      in         psel/penable, pready   paddr, pwdata, prdata
//
// Pushes, writes, refused operations and misses load their result straight into the
// output register; successful pops and reads pass through the registered read port
// of the element store and a read state first.
// Reset is synchronous; it empties the queue and clears both registers.
// A result waits in an output register; a new transaction is taken, when no store
// read is pending, while that register is free or being emptied in the same cycle.
module ring_buffer_deque_core
   import rbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // index [7:0], value [39:8]
   input  logic [OP_W-1:0]        req_tuser,   // operation [2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // data [31:0], length [40:32], zeros
   output logic [STATUS_W-1:0]    rsp_tuser,   // status [2:0]
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type             cfg;
   cmd_type             cmd;
   stat_type            stat;
   logic [FIELD_W-1:0]  rsp_data;
   logic [LENGTH_W-1:0] rsp_length;

   rbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .operation  (req_tuser),
      .index      (req_tdata[IDX_W-1:0]),
      .value      (req_tdata[IDX_W +: FIELD_W]),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_tuser),
      .rsp_length (rsp_length)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_length, rsp_data};

endmodule

### hdl/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/rbd_csr.sv
// Configuration registers behind an APB-style port: empty value and read-only flag.
// Depends on rbd_pkg.
module rbd_csr
   import rbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [FIELD_W-1:0]   empty_value_ff, empty_value_in;
   logic                 read_only_ff, read_only_in;
   logic [CSR_IDX_W-1:0] reg_index;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      empty_value_in = empty_value_ff;
      read_only_in   = read_only_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_EMPTY_VALUE: empty_value_in = FIELD_W'(csr_pwdata);
            REG_READ_ONLY:   read_only_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_EMPTY_VALUE: csr_prdata = CSR_DATA_W'(empty_value_ff);
         REG_READ_ONLY:   csr_prdata = CSR_DATA_W'(read_only_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_value_ff <= '0;
         read_only_ff   <= 1'b0;
      end else begin
         empty_value_ff <= empty_value_in;
         read_only_ff   <= read_only_in;
      end
   end

   assign cfg.empty_value = empty_value_ff;
   assign cfg.read_only   = read_only_ff;

endmodule

### hdl/rbd_ctrl.sv
// Controller state machine: accepts operations and sequences store reads
// into the result register. Depends on rbd_pkg.
module rbd_ctrl
   import rbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      out_free;

   assign out_free = !stat.rsp_valid || rsp_tready;

   always_comb begin
      state_in           = state_ff;
      req_tready         = 1'b0;
      cmd.accept         = 1'b0;
      cmd.capture_direct = 1'b0;
      cmd.capture_ram    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready         = out_free;
            cmd.accept         = req_tvalid && out_free;
            cmd.capture_direct = cmd.accept && !stat.needs_read;
            if (cmd.accept && stat.needs_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.capture_ram = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/rbd_datapath.sv
// Datapath: front pointer, element count, operation decode, element store
// and result register. Depends on rbd_pkg and rbd_ram.
module rbd_datapath
   import rbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  cfg_type             cfg,
   input  logic [OP_W-1:0]     operation,
   input  logic [IDX_W-1:0]    index,
   input  logic [FIELD_W-1:0]  value,
   input  logic                rsp_tready,
   output stat_type            stat,
   output logic                rsp_valid,
   output logic [FIELD_W-1:0]  rsp_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LENGTH_W-1:0] rsp_length
);

   logic [ADDR_W-1:0]   front_ff, front_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_data_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   logic [STATUS_W-1:0]   op_status;
   logic [FIELD_W-1:0]    direct_data;
   logic                  do_write, do_read, mutating, is_full, is_empty, out_of_range;
   logic [ADDR_W-1:0]     waddr, raddr, front_dec, front_inc;
   logic [COUNT_W-1:0]    logical_idx;
   logic [DATA_WIDTH-1:0] wdata, rdata;

   assign is_full      = count_ff == COUNT_W'(DEPTH);
   assign is_empty     = count_ff == '0;
   assign out_of_range = CMP_W'(index) >= CMP_W'(count_ff);
   assign logical_idx  = COUNT_W'(CMP_W'(index));
   assign front_dec    = (front_ff == '0) ? ADDR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc    = (front_ff == ADDR_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign wdata        = DATA_WIDTH'(value);
   assign mutating     = (operation == OP_PUSH_BACK) || (operation == OP_PUSH_FRONT) ||
                         (operation == OP_POP_BACK) || (operation == OP_POP_FRONT) ||
                         (operation == OP_WRITE);

   always_comb begin
      op_status   = STATUS_OK;
      direct_data = '0;
      do_write    = 1'b0;
      do_read     = 1'b0;
      waddr       = front_ff;
      raddr       = front_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      if (mutating && cfg.read_only) begin
         op_status = STATUS_READ_ONLY;
      end else begin
         case (operation)
            OP_PUSH_BACK: begin
               if (is_full) begin
                  op_status = STATUS_FULL;
               end else begin
                  do_write = 1'b1;
                  waddr    = wrap_slot(front_ff, count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  op_status = STATUS_FULL;
               end else begin
                  do_write = 1'b1;
                  waddr    = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  op_status   = STATUS_EMPTY;
                  direct_data = cfg.empty_value;
               end else begin
                  do_read  = 1'b1;
                  raddr    = wrap_slot(front_ff, count_ff - 1'b1);
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  op_status   = STATUS_EMPTY;
                  direct_data = cfg.empty_value;
               end else begin
                  do_read  = 1'b1;
                  raddr    = front_ff;
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_READ: begin
               if (out_of_range) begin
                  op_status   = STATUS_RANGE;
                  direct_data = cfg.empty_value;
               end else begin
                  do_read = 1'b1;
                  raddr   = wrap_slot(front_ff, logical_idx);
               end
            end
            OP_WRITE: begin
               if (out_of_range) begin
                  op_status = STATUS_RANGE;
               end else begin
                  do_write = 1'b1;
                  waddr    = wrap_slot(front_ff, logical_idx);
               end
            end
            default: ;
         endcase
      end
   end

   rbd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.accept && do_write),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.accept && do_read),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture_direct || cmd.capture_ram) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_direct) begin
         rsp_data_ff   <= direct_data;
         rsp_status_ff <= op_status;
         rsp_length_ff <= LENGTH_W'(count_in);
      end else if (cmd.capture_ram) begin
         rsp_data_ff   <= FIELD_W'(rdata);
         rsp_status_ff <= STATUS_OK;
         rsp_length_ff <= LENGTH_W'(count_ff);
      end
   end

   assign stat.needs_read = do_read;
   assign stat.rsp_valid  = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_length      = rsp_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("element count exceeds the capacity");

   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture_direct || cmd.capture_ram) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && do_write &&
       (operation == OP_PUSH_BACK || operation == OP_PUSH_FRONT))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("successful push did not grow the queue by one");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> (rsp_length_ff == LENGTH_W'(DEPTH)))
      else $error("full status reported with a length below the capacity");

endmodule

### tb/tb_ring_buffer_deque_core.sv
// Self-checking testbench for ring_buffer_deque_core: stream requests, stream results
// and APB register writes, checked against a behavioral deque kept in a scoreboard class.
// Depends on rbd_pkg and the ring_buffer_deque_core RTL.
module tb_ring_buffer_deque_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_CYCLES  = 400;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_type;

   typedef struct {
      logic [FIELD_W-1:0]  data;
      logic [STATUS_W-1:0] status;
      logic [LENGTH_W-1:0] length;
   } deque_result_type;

   class deque_scoreboard_type;
      logic [FIELD_W-1:0]  element_mirror[DEPTH];
      logic [ADDR_W-1:0]   front_mirror;
      logic [LENGTH_W-1:0] count_mirror;
      logic [FIELD_W-1:0]  empty_value;
      logic                read_only;
      deque_result_type    pending_results[$];
      int                  error_count;

      function new();
         front_mirror = '0;
         count_mirror = '0;
         empty_value  = '0;
         read_only    = 1'b0;
         error_count  = 0;
         foreach (element_mirror[i]) element_mirror[i] = '0;
      endfunction

      function int held();
         return int'(count_mirror);
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] reg_index, logic [FIELD_W-1:0] value);
         if (reg_index == REG_EMPTY_VALUE) begin
            empty_value = value;
         end else if (reg_index == REG_READ_ONLY) begin
            read_only = value[0];
         end
      endfunction

      function logic [ADDR_W-1:0] ring_slot(int logical);
         return ADDR_W'((int'(front_mirror) + logical) % DEPTH);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic [FIELD_W-1:0] value);
         deque_result_type result;
         logic             changes_queue;
         result.data   = '0;
         result.status = STATUS_OK;
         changes_queue = (op <= OP_POP_FRONT) || (op == OP_WRITE);
         if (changes_queue && read_only) begin
            result.status = STATUS_READ_ONLY;
         end else begin
            case (op)
               OP_PUSH_BACK: begin
                  if (int'(count_mirror) >= DEPTH) begin
                     result.status = STATUS_FULL;
                  end else begin
                     element_mirror[ring_slot(int'(count_mirror))] = value;
                     count_mirror++;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (int'(count_mirror) >= DEPTH) begin
                     result.status = STATUS_FULL;
                  end else begin
                     front_mirror = ADDR_W'((int'(front_mirror) + DEPTH - 1) % DEPTH);
                     element_mirror[front_mirror] = value;
                     count_mirror++;
                  end
               end
               OP_POP_BACK: begin
                  if (count_mirror == 0) begin
                     result.data   = empty_value;
                     result.status = STATUS_EMPTY;
                  end else begin
                     count_mirror--;
                     result.data = element_mirror[ring_slot(int'(count_mirror))];
                  end
               end
               OP_POP_FRONT: begin
                  if (count_mirror == 0) begin
                     result.data   = empty_value;
                     result.status = STATUS_EMPTY;
                  end else begin
                     result.data  = element_mirror[front_mirror];
                     front_mirror = ADDR_W'((int'(front_mirror) + 1) % DEPTH);
                     count_mirror--;
                  end
               end
               OP_READ: begin
                  if (int'(idx) >= int'(count_mirror)) begin
                     result.data   = empty_value;
                     result.status = STATUS_RANGE;
                  end else begin
                     result.data = element_mirror[ring_slot(int'(idx))];
                  end
               end
               OP_WRITE: begin
                  if (int'(idx) >= int'(count_mirror)) begin
                     result.status = STATUS_RANGE;
                  end else begin
                     element_mirror[ring_slot(int'(idx))] = value;
                  end
               end
               default: begin
               end
            endcase
         end
         result.length = count_mirror;
         pending_results.insert(pending_results.size(), result);
      endfunction

      function void check_response(logic [FIELD_W-1:0] data, logic [STATUS_W-1:0] status,
                                   logic [LENGTH_W-1:0] length);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result data=%h status=%0d length=%0d",
                     $time, data, status, length);
            error_count++;
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         if (data !== want.data) begin
            $display("%0t: data mismatch, expected %h, actual %h", $time, want.data, data);
            error_count++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            error_count++;
         end
         if (length !== want.length) begin
            $display("%0t: length mismatch, expected %0d, actual %0d",
                     $time, want.length, length);
            error_count++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // index [7:0], value [39:8]
   logic [OP_W-1:0]        req_tuser = '0;   // operation [2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // data [31:0], length [40:32], zeros
   logic [STATUS_W-1:0]    rsp_tuser;        // status [2:0]
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   deque_scoreboard_type deque_book = new();
   bit                   source_idles = 1'b1;
   bit                   sink_idles = 1'b1;
   bit                   hold_request = 1'b0;
   int                   items_sent = 0;

   ring_buffer_deque_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #18_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int source_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!source_idles || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin : result_sink
      int stall_left;
      bit hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            deque_book.check_response(rsp_tdata[FIELD_W-1:0], rsp_tuser,
                                      rsp_tdata[FIELD_W +: LENGTH_W]);
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sink_idles && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                        input logic [FIELD_W-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, idx};
      do @(posedge clock); while (!req_tready);
      deque_book.note_request(op, idx, value);
      items_sent++;
      gap = source_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (deque_book.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [FIELD_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({reg_index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      deque_book.set_register(reg_index, value);
   endtask

   task automatic pick_item(input phase_mode_type mode, output logic [OP_W-1:0] op,
                            output logic [IDX_W-1:0] idx, output logic [FIELD_W-1:0] value);
      int roll;
      int held;
      int tail_push_top;
      int head_push_top;
      int tail_pop_top;
      int head_pop_top;
      int read_top;
      int write_top;
      held = deque_book.held();
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            tail_push_top = 40; head_push_top = 75; tail_pop_top = 82;
            head_pop_top = 88; read_top = 94; write_top = 99;
         end
         MODE_DRAIN: begin
            tail_push_top = 8; head_push_top = 15; tail_pop_top = 50;
            head_pop_top = 85; read_top = 92; write_top = 98;
         end
         default: begin
            tail_push_top = 17; head_push_top = 34; tail_pop_top = 50;
            head_pop_top = 66; read_top = 82; write_top = 97;
         end
      endcase
      if (roll < tail_push_top) op = OP_PUSH_BACK;
      else if (roll < head_push_top) op = OP_PUSH_FRONT;
      else if (roll < tail_pop_top) op = OP_POP_BACK;
      else if (roll < head_pop_top) op = OP_POP_FRONT;
      else if (roll < read_top) op = OP_READ;
      else if (roll < write_top) op = OP_WRITE;
      else op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
      if (held > 0 && $urandom_range(0, 99) < 80) begin
         idx = IDX_W'($urandom_range(0, held - 1));
      end else begin
         idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      end
      value = $urandom;
   endtask

   initial begin : stimulus
      int             phase_no;
      int             phase_len;
      int             roll;
      phase_mode_type mode;
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   idx;
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] empty_choice;
      logic               read_only_choice;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_EMPTY_VALUE, 32'hFFFF_FFFF);
      csr_write(REG_READ_ONLY, 32'd0);
      @(posedge clock);

      issue(OP_POP_BACK, 8'd0, 32'd0);
      issue(OP_POP_FRONT, 8'd0, 32'd0);
      issue(OP_READ, 8'd0, 32'd0);
      issue(OP_WRITE, 8'd0, 32'h1234_5678);
      issue(OP_PUSH_BACK, 8'd0, 32'h0000_0000);
      issue(OP_PUSH_BACK, 8'd0, 32'hFFFF_FFFF);
      issue(OP_PUSH_FRONT, 8'd0, 32'h5A5A_A5A5);
      issue(OP_READ, 8'd0, 32'd0);
      issue(OP_READ, 8'd2, 32'd0);
      issue(OP_READ, 8'd255, 32'd0);
      issue(OP_WRITE, 8'd1, 32'hDEAD_BEEF);
      issue(OP_WRITE, 8'd3, 32'hCAFE_F00D);
      issue(OP_READ, 8'd1, 32'd0);
      issue(OP_UNUSED_A, 8'd255, 32'hFFFF_FFFF);
      issue(OP_UNUSED_B, 8'd0, 32'd0);
      issue(OP_POP_FRONT, 8'd0, 32'd0);
      issue(OP_POP_BACK, 8'd0, 32'd0);
      wait_idle();

      csr_write(REG_READ_ONLY, 32'd1);
      @(posedge clock);
      issue(OP_PUSH_BACK, 8'd0, 32'h1111_1111);
      issue(OP_PUSH_FRONT, 8'd0, 32'h2222_2222);
      issue(OP_POP_BACK, 8'd0, 32'd0);
      issue(OP_POP_FRONT, 8'd0, 32'd0);
      issue(OP_WRITE, 8'd0, 32'h3333_3333);
      issue(OP_READ, 8'd0, 32'd0);
      issue(OP_READ, 8'd1, 32'd0);
      wait_idle();

      csr_write(REG_READ_ONLY, 32'd0);
      csr_write(REG_EMPTY_VALUE, 32'd0);
      @(posedge clock);
      issue(OP_POP_BACK, 8'd0, 32'd0);
      issue(OP_POP_BACK, 8'd0, 32'd0);
      wait_idle();

      phase_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase_no++;
         roll = $urandom_range(0, 2);
         empty_choice = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
         read_only_choice = (phase_no > 2) && ($urandom_range(0, 99) < 15);
         csr_write(REG_EMPTY_VALUE, empty_choice);
         csr_write(REG_READ_ONLY, {31'd0, read_only_choice});
         @(posedge clock);

         roll = $urandom_range(0, 2);
         mode = (roll == 0) ? MODE_FILL : (roll == 1) ? MODE_DRAIN : MODE_MIXED;
         if (phase_no == 1) begin
            mode = MODE_FILL;
         end
         source_idles = (phase_no > 1) && ($urandom_range(0, 3) != 0);
         sink_idles   = (phase_no > 1) && ($urandom_range(0, 3) != 0);
         phase_len = read_only_choice ? $urandom_range(20, 40) : $urandom_range(100, 320);
         if (phase_len > RANDOM_ITEMS - items_sent) begin
            phase_len = RANDOM_ITEMS - items_sent;
         end
         if (phase_no == 1) begin
            hold_request = 1'b1;
         end

         repeat (phase_len) begin
            pick_item(mode, op, idx, value);
            issue(op, idx, value);
         end
         wait_idle();
      end

      source_idles = 1'b0;
      sink_idles   = 1'b0;
      wait_idle();
      repeat (10) @(posedge clock);
      if (deque_book.error_count == 0 && deque_book.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hdl/rbd_pkg.sv
hdl/rbd_ram.sv
hdl/rbd_csr.sv
hdl/rbd_ctrl.sv
hdl/rbd_datapath.sv
hdl/ring_buffer_deque_core.sv
tb/tb_ring_buffer_deque_core.sv
